>>> src/lrb_pkg.sv
// Shared types and constants for the link reconnect backoff supervisor.
// No dependencies; imported by every module of the block.
package lrb_pkg;

  // Field widths
  localparam int unsigned TIMEOUT_W = 20;
  localparam int unsigned CAP_W     = 17;
  localparam int unsigned AGE_W     = 32;
  localparam int unsigned ATT_W     = 5;
  localparam int unsigned WAIT_W    = CAP_W + 10;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 32;

  // Saturation limit of the failed attempt counter
  localparam logic [ATT_W-1:0] ATTEMPT_CAP = 5'd31;
  localparam int unsigned      MS_PER_SEC  = 1000;

  // Register reset values
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 20'd30000;
  localparam logic [CAP_W-1:0]     CAP_RST     = 17'd300;
  localparam logic                 BROKER_RST  = 1'b1;

  // Register indexes (word address bits)
  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_CAP     = 2'd1;
  localparam logic [1:0] REG_BROKER  = 2'd2;

  typedef enum logic [1:0] {
    MODE_CONNECT = 2'd0,
    MODE_POLL    = 2'd1,
    MODE_PUBLISH = 2'd2,
    MODE_TICK    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PUB_OK        = 2'd0,
    PUB_NOT_READY = 2'd1,
    PUB_SEND_FAIL = 2'd2,
    PUB_NONE      = 2'd3
  } pub_status_t;

  // Reported connection state codes
  localparam logic [1:0] CODE_IDLE       = 2'd0;
  localparam logic [1:0] CODE_CONNECTING = 2'd1;
  localparam logic [1:0] CODE_READY      = 2'd2;
  localparam logic [1:0] CODE_BACKOFF    = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE       = 4'b0001,
    ST_CONNECTING = 4'b0010,
    ST_READY      = 4'b0100,
    ST_BACKOFF    = 4'b1000
  } state_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] attempt_limit_ms;
    logic [CAP_W-1:0]     max_backoff_seconds;
    logic                 broker_configured;
  } cfg_t;

  typedef struct packed {
    mode_t mode;
    logic  link_up;
    logic  session_ok;
    logic  session_up;
    logic  send_ok;
  } item_t;

  typedef struct packed {
    logic [1:0]       conn_state;
    pub_status_t      publish_status;
    logic             start_link;
    logic             session_attempt;
    logic [ATT_W-1:0] retry_count;
  } result_t;

endpackage

>>> src/lrb_cfg.sv
// Configuration register bank behind the APB-style port.
// Depends on lrb_pkg for register indexes, widths and reset values.
module lrb_cfg
  import lrb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Write on the access phase of a write beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attempt_limit_ms    <= TIMEOUT_RST;
      cfg_r.max_backoff_seconds <= CAP_RST;
      cfg_r.broker_configured   <= BROKER_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_TIMEOUT: cfg_r.attempt_limit_ms    <= pwdata[TIMEOUT_W-1:0];
        REG_CAP:     cfg_r.max_backoff_seconds <= pwdata[CAP_W-1:0];
        REG_BROKER:  cfg_r.broker_configured   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[3:2])
      REG_TIMEOUT: prdata = DATA_W'(cfg_r.attempt_limit_ms);
      REG_CAP:     prdata = DATA_W'(cfg_r.max_backoff_seconds);
      REG_BROKER:  prdata = DATA_W'(cfg_r.broker_configured);
      default:     prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

>>> src/lrb_fsm.sv
// Connection state machine: state, state age and attempt counter, with the
// next-state and result logic for one item. Depends on lrb_pkg.
module lrb_fsm
  import lrb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  state_t           state_r, state_nxt;
  logic [AGE_W-1:0] age_r, age_nxt;
  logic [ATT_W-1:0] att_r, att_nxt;

  logic [ATT_W-1:0]  att_bump;
  logic [CAP_W-1:0]  pow_sec;
  logic [CAP_W-1:0]  wait_sec;
  logic [WAIT_W-1:0] wait_ms;
  logic              timed_out;
  logic              backoff_done;
  logic              start;
  logic              attempt;
  pub_status_t       pub;
  logic [1:0]        conn_code;

  // Saturating attempt increment
  assign att_bump = (att_r < ATTEMPT_CAP) ? att_r + ATT_W'(1) : att_r;

  // Backoff wait: min(2^attempts, cap) seconds, in ms
  always_comb begin
    pow_sec = CAP_W'(1) << att_r;
    if (att_r >= ATT_W'(CAP_W)) begin
      wait_sec = cfg.max_backoff_seconds;
    end else if (pow_sec > cfg.max_backoff_seconds) begin
      wait_sec = cfg.max_backoff_seconds;
    end else begin
      wait_sec = pow_sec;
    end
  end

  assign wait_ms      = WAIT_W'(wait_sec) * WAIT_W'(MS_PER_SEC);
  assign timed_out    = age_r >= AGE_W'(cfg.attempt_limit_ms);
  assign backoff_done = age_r >= AGE_W'(wait_ms);

  // Next state for the item at the head of the input register
  always_comb begin
    state_nxt = state_r;
    age_nxt   = age_r;
    att_nxt   = att_r;
    start     = 1'b0;
    attempt   = 1'b0;
    pub       = PUB_NONE;
    unique case (item.mode)
      MODE_CONNECT: begin
        if (state_r == ST_IDLE || state_r == ST_BACKOFF) begin
          state_nxt = ST_CONNECTING;
          age_nxt   = '0;
          start     = 1'b1;
        end
      end
      MODE_POLL: begin
        unique case (state_r)
          ST_CONNECTING: begin
            if (timed_out) begin
              att_nxt   = att_bump;
              state_nxt = ST_BACKOFF;
              age_nxt   = '0;
            end else if (item.link_up) begin
              attempt = cfg.broker_configured;
              if (!cfg.broker_configured || item.session_ok) begin
                att_nxt   = '0;
                state_nxt = ST_READY;
                age_nxt   = '0;
              end
            end
          end
          ST_READY: begin
            if (!item.link_up || (cfg.broker_configured && !item.session_up)) begin
              att_nxt   = att_bump;
              state_nxt = ST_BACKOFF;
              age_nxt   = '0;
            end
          end
          ST_BACKOFF: begin
            if (backoff_done) begin
              state_nxt = ST_CONNECTING;
              age_nxt   = '0;
              start     = 1'b1;
            end
          end
          default: ;
        endcase
      end
      MODE_PUBLISH: begin
        if (state_r != ST_READY) begin
          pub = PUB_NOT_READY;
        end else begin
          pub = item.send_ok ? PUB_OK : PUB_SEND_FAIL;
        end
      end
      default: begin
        if (age_r != '1) begin
          age_nxt = age_r + AGE_W'(1);
        end
      end
    endcase
  end

  // Advance state only when an item is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      age_r   <= '0;
      att_r   <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
      age_r   <= age_nxt;
      att_r   <= att_nxt;
    end
  end

  // Encode the reported state
  always_comb begin
    unique case (state_nxt)
      ST_CONNECTING: conn_code = CODE_CONNECTING;
      ST_READY:      conn_code = CODE_READY;
      ST_BACKOFF:    conn_code = CODE_BACKOFF;
      default:       conn_code = CODE_IDLE;
    endcase
  end

  assign res.conn_state      = conn_code;
  assign res.publish_status  = pub;
  assign res.start_link      = start;
  assign res.session_attempt = attempt;
  assign res.retry_count     = att_nxt;

endmodule

>>> src/link_reconnect_backoff_fsm.sv
// Link reconnect supervisor with exponential backoff: top level.
// An input beat becomes a result beat through the input register, then the result register.
// Throughput: one item per cycle while out_stall is low; the state update is a single pass.
// Reset (rst_n low, synchronous): state idle, age and attempts zero, both
// registers empty, configuration at its reset values.
module link_reconnect_backoff_fsm
  import lrb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_mode,
  input  logic              in_link_up,
  input  logic              in_session_ok,
  input  logic              in_session_up,
  input  logic              in_send_ok,
  // Result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_conn_state,
  output logic [1:0]        out_publish_status,
  output logic              out_start_link,
  output logic              out_session_attempt,
  output logic [ATT_W-1:0]  out_retry_count,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg;
  item_t   item_r;
  logic    in_valid_r, in_valid_nxt;
  result_t res, res_r;
  logic    out_valid_r, out_valid_nxt;
  logic    advance;
  logic    in_acc;
  logic    fire;
  item_t   item_in;

  // Handshake control
  assign advance       = ~out_valid_r | ~out_stall;
  assign in_stall      = in_valid_r & ~advance;
  assign in_acc        = in_valid & ~in_stall;
  assign fire          = in_valid_r & advance;
  assign in_valid_nxt  = in_acc | (in_valid_r & ~advance);
  assign out_valid_nxt = fire | (out_valid_r & out_stall);

  assign item_in.mode       = mode_t'(in_mode);
  assign item_in.link_up    = in_link_up;
  assign item_in.session_ok = in_session_ok;
  assign item_in.session_up = in_session_up;
  assign item_in.send_ok    = in_send_ok;

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= item_in;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  lrb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lrb_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (fire),
    .item  (item_r),
    .res   (res)
  );

  assign out_valid           = out_valid_r;
  assign out_conn_state      = res_r.conn_state;
  assign out_publish_status  = res_r.publish_status;
  assign out_start_link      = res_r.start_link;
  assign out_session_attempt = res_r.session_attempt;
  assign out_retry_count     = res_r.retry_count;

endmodule
